@@ rtl/vlt_pkg.sv @@
// ----------------------------------------------------------------------------
// vlt_pkg
// Shared types, codes and sizes of the value list table and its cell chain.
// ----------------------------------------------------------------------------
package vlt_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FIELD_W = 5;
   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] entry_type;
   typedef logic [CNT_W-1:0]          count_type;

   typedef enum logic [1:0] {
      KIND_APPEND,
      KIND_DELETE,
      KIND_SORT,
      KIND_SEARCH
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_NOT_FOUND,
      STAT_EMPTY
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_ROTATE,
      CELL_SHIFT,
      CELL_SORT
   } cell_op_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      entry_type   value;   // append data
      entry_type   wrap;    // head entry, goes to the tail on rotate
      count_type   count;   // entries held
      count_type   mark;    // first cell that closes the gap on delete
      logic        phase;   // odd/even pairing of the sort round
   } cell_cmd_type;

   // count to a 5-bit result field, zero-extended or cut to the low bits
   function automatic logic [FIELD_W-1:0] to_field(input count_type c);
      logic [CNT_W+FIELD_W-1:0] t;
      t = {{FIELD_W{1'b0}}, c};
      return t[FIELD_W-1:0];
   endfunction

endpackage

@@ rtl/vlt_cell.sv @@
// ----------------------------------------------------------------------------
// vlt_cell
// One slot of the list: holds an entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
module vlt_cell
   import vlt_pkg::*;
(
   input  logic         clock,
   input  count_type    idx,
   input  cell_cmd_type cmd,
   input  entry_type    left_data,
   input  entry_type    right_data,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;
   count_type pos;
   logic      lower;

   assign pos   = idx + count_type'(1);
   assign lower = (idx[0] == cmd.phase);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_LOAD: begin
            if (idx == cmd.count) begin
               entry_in = cmd.value;
            end
         end
         CELL_ROTATE: begin
            if (pos == cmd.count) begin
               entry_in = cmd.wrap;
            end else if (pos < cmd.count) begin
               entry_in = right_data;
            end
         end
         CELL_SHIFT: begin
            if (idx >= cmd.mark && pos < cmd.count) begin
               entry_in = right_data;
            end
         end
         CELL_SORT: begin
            // odd-even transposition: lower cell keeps the min, upper the max
            if (lower) begin
               if (pos < cmd.count && entry_ff > right_data) begin
                  entry_in = right_data;
               end
            end else if (idx != '0 && idx < cmd.count && left_data > entry_ff) begin
               entry_in = left_data;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/value_list_table.sv @@
// ----------------------------------------------------------------------------
// value_list_table
// Ordered list of signed values: append, delete first match, sort, search.
// ----------------------------------------------------------------------------
// One item at a time. The entries sit in a chain of DEPTH cells. Search and
// delete rotate the list once through the chain while the head cell is
// compared, and a delete that finds a match then closes the gap; sort runs
// one odd-even round over the chain per cycle. Sort, search and delete on an
// empty list go straight to the response. A new item is taken while the
// previous result still waits on the response side. No clearing after reset:
// entries beyond the count are never read.
module value_list_table
   import vlt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_position,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_is_empty
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_SCAN,
      S_SHIFT,
      S_SORT,
      S_RESP
   } state_type;

   state_type    state_ff;
   kind_type     kind_ff;
   entry_type    value_ff;
   count_type    count_ff;
   count_type    step_ff;
   count_type    hit_ff;
   logic         found_ff;
   status_type   status_ff;
   count_type    position_ff;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_status_ff;
   logic [4:0]   rsp_position_ff;
   logic [4:0]   rsp_entry_count_ff;
   logic         rsp_is_empty_ff;

   cell_cmd_type cmd;
   entry_type    cell_data [DEPTH];
   logic         head_eq;
   logic         last_step;
   count_type    hit_now;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

   assign head_eq   = (cell_data[0] == value_ff);
   assign last_step = (step_ff == count_ff - count_type'(1));
   assign hit_now   = found_ff ? hit_ff : step_ff;

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.value = value_ff;
      cmd.wrap  = cell_data[0];
      cmd.count = count_ff;
      cmd.mark  = hit_ff;
      cmd.phase = step_ff[0];
      case (state_ff)
         S_APPEND: cmd.op = CELL_LOAD;
         S_SCAN:   cmd.op = CELL_ROTATE;
         S_SHIFT:  cmd.op = CELL_SHIFT;
         S_SORT:   cmd.op = CELL_SORT;
         default:  cmd.op = CELL_HOLD;
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type left_data;
      entry_type right_data;
      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid
         assign left_data = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_next
         assign right_data = cell_data[g+1];
      end
      vlt_cell u_cell (
         .clock      (clock),
         .idx        (count_type'(g)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (cell_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
      end else begin
         // in S_RESP the result register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff     <= kind_type'(req_kind);
                  value_ff    <= req_value;
                  step_ff     <= '0;
                  found_ff    <= 1'b0;
                  status_ff   <= STAT_OK;
                  position_ff <= '0;
                  case (kind_type'(req_kind))
                     KIND_APPEND: begin
                        state_ff <= S_APPEND;
                     end
                     KIND_SORT: begin
                        state_ff <= (count_ff == '0) ? S_RESP : S_SORT;
                     end
                     KIND_DELETE, KIND_SEARCH: begin
                        if (count_ff == '0) begin
                           status_ff <= STAT_EMPTY;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_APPEND: begin
               if (count_ff == count_type'(DEPTH)) begin
                  status_ff <= STAT_FULL;
               end else begin
                  count_ff <= count_ff + count_type'(1);
               end
               state_ff <= S_RESP;
            end
            S_SCAN: begin
               // head cell holds entry number step_ff during this pass
               if (head_eq && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff   <= step_ff;
               end
               step_ff <= step_ff + count_type'(1);
               if (last_step) begin
                  if (!(found_ff || head_eq)) begin
                     status_ff <= STAT_NOT_FOUND;
                     state_ff  <= S_RESP;
                  end else if (kind_ff == KIND_DELETE) begin
                     hit_ff   <= hit_now;
                     state_ff <= S_SHIFT;
                  end else begin
                     position_ff <= hit_now + count_type'(1);
                     state_ff    <= S_RESP;
                  end
               end
            end
            S_SHIFT: begin
               count_ff <= count_ff - count_type'(1);
               state_ff <= S_RESP;
            end
            S_SORT: begin
               step_ff <= step_ff + count_type'(1);
               if (last_step) begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= status_ff;
                  rsp_position_ff    <= to_field(position_ff);
                  rsp_entry_count_ff <= to_field(count_ff);
                  rsp_is_empty_ff    <= (count_ff == '0);
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count above depth");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("no work started after request transfer");

   a_position_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position != 5'd0 |-> rsp_status == STAT_OK)
      else $error("position reported with error status");

   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("result not presented");
`endif

endmodule

@@ tb/sv/value_list_table_tb.sv @@
// ----------------------------------------------------------------------------
// value_list_table_tb
// Drives append, delete, sort and search operations into the value list
// table and checks every response against a predicted copy of the list.
// ----------------------------------------------------------------------------
module value_list_table_tb
   import vlt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_OPS  = 270;

   typedef struct {
      status_type status;
      logic [4:0] position;
      logic [4:0] entry_count;
      logic       is_empty;
   } list_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_position;
   logic [4:0]         rsp_entry_count;
   logic               rsp_is_empty;

   // predicted list contents
   entry_type      held_vals [DEPTH];
   int             held_count = 0;
   list_reply_type pending_replies [$];
   entry_type      value_pool [8];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   bit growing = 1'b1;

   value_list_table u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #5 clock = ~clock;

   // apply one operation to the predicted list, return the expected response
   function automatic list_reply_type apply_list_op(input kind_type k, input entry_type v);
      list_reply_type r;
      int             hit;
      entry_type      t;
      r.status   = STAT_OK;
      r.position = '0;
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_vals[i] == v) hit = i;
      end
      case (k)
         KIND_APPEND: begin
            if (held_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               held_vals[held_count] = v;
               held_count++;
            end
         end
         KIND_DELETE: begin
            if (held_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (hit < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               for (int i = hit; i < held_count - 1; i++) held_vals[i] = held_vals[i + 1];
               held_count--;
            end
         end
         KIND_SORT: begin
            for (int i = 0; i < held_count - 1; i++) begin
               for (int j = i + 1; j < held_count; j++) begin
                  if (held_vals[i] > held_vals[j]) begin
                     t = held_vals[i];
                     held_vals[i] = held_vals[j];
                     held_vals[j] = t;
                  end
               end
            end
         end
         default: begin
            if (held_count == 0) r.status = STAT_EMPTY;
            else if (hit < 0) r.status = STAT_NOT_FOUND;
            else r.position = 5'(hit + 1);
         end
      endcase
      r.entry_count = 5'(held_count);
      r.is_empty    = (held_count == 0);
      return r;
   endfunction

   // lookups mostly hit an entry that is held
   function automatic entry_type pick_value(input bit lookup);
      int r;
      r = $urandom_range(0, 9);
      if (lookup && held_count > 0 && r < 6) return held_vals[$urandom_range(0, held_count - 1)];
      if (r < 8) return value_pool[$urandom_range(0, 7)];
      return entry_type'($urandom);
   endfunction

   task automatic flag_error(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endtask

   task automatic send_op(input kind_type k, input entry_type v);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= k;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_replies.push_back(apply_list_op(k, v));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_op(KIND_SEARCH, 5);
      send_op(KIND_DELETE, 5);
      send_op(KIND_SORT, 0);
      send_op(KIND_APPEND, 7);
      send_op(KIND_SORT, 0);
      send_op(KIND_SEARCH, 7);
      send_op(KIND_DELETE, 7);
      send_op(KIND_APPEND, 32'sh7fffffff);
      send_op(KIND_APPEND, 32'sh80000000);
      send_op(KIND_APPEND, 0);
      send_op(KIND_APPEND, -1);
      send_op(KIND_APPEND, 32'sh7fffffff);
      send_op(KIND_SORT, 32'sh5a5a5a5a);
      send_op(KIND_SEARCH, 32'sh80000000);
      send_op(KIND_SEARCH, 32'sh7fffffff);
      send_op(KIND_SEARCH, 12345);
      send_op(KIND_DELETE, 12345);
      send_op(KIND_DELETE, 32'sh7fffffff);
      send_op(KIND_DELETE, 32'sh80000000);
      send_op(KIND_SEARCH, 32'sh7fffffff);
      wait_drained();
   endtask

   task automatic test_full_list();
      while (held_count < DEPTH) send_op(KIND_APPEND, entry_type'($urandom));
      send_op(KIND_APPEND, 32'sh80000000);
      send_op(KIND_APPEND, -1);
      send_op(KIND_SEARCH, held_vals[DEPTH - 1]);
      send_op(KIND_SORT, 0);
      send_op(KIND_SEARCH, held_vals[DEPTH - 1]);
      send_op(KIND_DELETE, held_vals[DEPTH - 1]);
      send_op(KIND_APPEND, 32'sh7fffffff);
      wait_drained();
   endtask

   // grow toward full, then shrink toward empty, with some noise mixed in
   task automatic test_random_ops(input int n);
      kind_type  k;
      entry_type v;
      int        r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            k = kind_type'($urandom_range(0, 3));
            v = entry_type'($urandom);
         end else begin
            r = $urandom_range(0, 99);
            if (growing)
               k = r < 55 ? KIND_APPEND : r < 70 ? KIND_DELETE : r < 80 ? KIND_SORT : KIND_SEARCH;
            else
               k = r < 15 ? KIND_APPEND : r < 70 ? KIND_DELETE : r < 80 ? KIND_SORT : KIND_SEARCH;
            v = pick_value(k != KIND_APPEND);
         end
         send_op(k, v);
         if (held_count == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
         if (held_count == 0) growing = 1'b1;
      end
      wait_drained();
   endtask

   // response side stalls while the request side keeps pushing
   task automatic test_backpressure();
      int saved_idle;
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      hold_req = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) send_op(kind_type'($urandom_range(0, 3)), pick_value(1'b1));
      send_idle_pct = saved_idle;
      wait_drained();
   endtask

   initial begin
      value_pool[0] = 32'sh80000000;
      value_pool[1] = 32'sh7fffffff;
      value_pool[2] = 0;
      value_pool[3] = -1;
      for (int i = 4; i < 8; i++) value_pool[i] = entry_type'($urandom);
      send_idle_pct = 14;
      recv_idle_pct = 77;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_list();
      test_random_ops(RANDOM_OPS);
      send_idle_pct = 77;
      recv_idle_pct = 14;
      test_random_ops(RANDOM_OPS);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ops(RANDOM_OPS);
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("value_list_table_tb OK");
      end else begin
         $display("value_list_table_tb NOT OK");
      end
      $finish;
   end

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            flag_error($sformatf("response with none outstanding: status %0d count %0d",
                                 rsp_status, rsp_entry_count));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_position !== want.position ||
                rsp_entry_count !== want.entry_count || rsp_is_empty !== want.is_empty)
               flag_error($sformatf(
                  "exp status %0d pos %0d count %0d empty %0d, got %0d %0d %0d %0d",
                  want.status, want.position, want.entry_count, want.is_empty,
                  rsp_status, rsp_position, rsp_entry_count, rsp_is_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("value_list_table_tb NOT OK");
         $finish;
      end
   end

endmodule

@@ value_list_table.f @@
rtl/vlt_pkg.sv
rtl/vlt_cell.sv
rtl/value_list_table.sv
tb/sv/value_list_table_tb.sv
